[rtl/core/depth_drop_hysteresis_detector_defines.svh]
// Assertion macros for the depth drop hysteresis detector.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef DEPTH_DROP_HYSTERESIS_DETECTOR_DEFINES_SVH
`define DEPTH_DROP_HYSTERESIS_DETECTOR_DEFINES_SVH

// same-cycle implication
`define DDHD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DDHD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/ddhd_pkg.sv]
// Shared types, constants and the alpha table for the depth drop detector.
// No dependencies.
package ddhd_pkg;

   localparam int SymbolCount  = 256;
   localparam int AlphaEntries = 256;
   localparam int SymIdxW      = (SymbolCount > 1) ? $clog2(SymbolCount) : 1;
   localparam int AlphaIdxW    = $clog2(AlphaEntries);

   localparam int SymW    = 8;
   localparam int TsW     = 63;
   localparam int VolW    = 32;
   localparam int SumW    = 40;
   localparam int BaseW   = 56;
   localparam int RatioW  = 24;
   localparam int AlphaW  = 17;
   localparam int DivNumW = 72;
   localparam int DivDenW = 56;
   localparam int DivCntW = 5;
   localparam int CsrIdxW = 3;
   localparam int CsrDatW = 32;
   localparam int ReqDatW = 104;
   localparam int RspDatW = 32;

   // register indexes
   localparam logic [CsrIdxW-1:0] CsrSideSelect = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrWindow     = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrWarmup     = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrEnterRatio = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrExitRatio  = 3'd4;
   localparam logic [CsrIdxW-1:0] CsrCooldown   = 3'd5;

   localparam logic ActEnter = 1'b0;
   localparam logic ActExit  = 1'b1;

   localparam logic [AlphaW-1:0] AlphaOne = 17'd65536;
   localparam logic [RatioW-1:0] RatioMax = 24'hFFFFFF;
   localparam logic [SumW-1:0]   SumMax   = 40'hFFFFFFFFFF;

   typedef struct packed {
      logic              side_select;
      logic [31:0]       window_us;
      logic [31:0]       warmup_us;
      logic [RatioW-1:0] enter_ratio;
      logic [RatioW-1:0] exit_ratio;
      logic [31:0]       holdoff_us;
   } cfg_type;

   typedef struct packed {
      logic [SymW-1:0] sym;
      logic [TsW-1:0]  ts;
      logic [SumW-1:0] vol;
   } quote_type;

   typedef struct packed {
      logic [BaseW-1:0] base;
      logic [TsW-1:0]   first;
      logic [TsW-1:0]   prev;
      logic [TsW-1:0]   enter;
      logic             valid;
      logic             fired;
      logic             seen;
   } row_type;

   localparam int RowW = $bits(row_type);

   typedef struct packed {
      logic               start;
      logic [DivNumW-1:0] num;
      logic [DivDenW-1:0] den;
      logic [DivCntW-1:0] nbits;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [RatioW-1:0] quot;
   } div_rsp_type;

   typedef logic [AlphaW-1:0] alpha_rom_type [AlphaEntries];

   // alpha(i) = 1 - r^i, r ~ exp(-8/AlphaEntries) in Q0.32
   function automatic alpha_rom_type alpha_rom_build();
      alpha_rom_type rom;
      logic [63:0]   h;
      logic [63:0]   term;
      logic [63:0]   r;
      logic [63:0]   p;
      logic [63:0]   full;
      h    = 64'(64'd1 << 35) / 64'(AlphaEntries);
      term = 64'd1 << 32;
      r    = 64'd1 << 32;
      p    = 64'd1 << 32;
      full = 64'd1 << 32;
      for (int n = 1; n <= 24; n++) begin
         term = ((term * h) >> 32) / 64'(n);
         if ((n % 2) == 1) r = r - term;
         else r = r + term;
      end
      for (int i = 0; i < AlphaEntries; i++) begin
         rom[i] = AlphaW'((full - p + 64'd32768) >> 16);
         p      = (p * r + 64'h80000000) >> 32;
      end
      return rom;
   endfunction

   localparam alpha_rom_type AlphaRom = alpha_rom_build();

endpackage

[rtl/core/ddhd_ram.sv]
// Generic single write port RAM with registered read.
// No dependencies.
module ddhd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/core/ddhd_front.sv]
// Front end: takes level transactions, sums the selected side, hands
// finished quotes to the queue. Depends on ddhd_pkg.
module ddhd_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        side_select,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ddhd_pkg::SymW-1:0]   sym,
   input  logic [ddhd_pkg::TsW-1:0]    ts,
   input  logic                        side,
   input  logic [ddhd_pkg::VolW-1:0]   vol,
   input  logic                        last,
   input  logic                        q_full,
   output logic                        q_push,
   output ddhd_pkg::quote_type         q_data
);
   import ddhd_pkg::*;

   logic [SumW-1:0] sum_ff, sum_in;
   logic [SumW:0]   sum_wide;
   logic [SumW-1:0] sum_sat;
   logic            accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      sum_wide = {1'b0, sum_ff};
      if (side == side_select) sum_wide = sum_wide + (SumW+1)'(vol);
      sum_sat = sum_wide[SumW] ? SumMax : sum_wide[SumW-1:0];
      sum_in  = sum_ff;
      if (accept) sum_in = last ? '0 : sum_sat;
   end

   assign q_push     = accept && last;
   assign q_data.sym = sym;
   assign q_data.ts  = ts;
   assign q_data.vol = sum_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end
endmodule

[rtl/core/ddhd_fifo.sv]
// Two-entry quote queue between front and back end.
// Depends on ddhd_pkg.
module ddhd_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ddhd_pkg::quote_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output ddhd_pkg::quote_type head
);
   import ddhd_pkg::*;

   quote_type  entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

[rtl/core/ddhd_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on ddhd_pkg.
module ddhd_div (
   input  logic                  clock,
   input  logic                  reset,
   input  ddhd_pkg::div_req_type req,
   output ddhd_pkg::div_rsp_type rsp
);
   import ddhd_pkg::*;

   localparam int ShW = DivDenW + RatioW;

   logic [DivNumW-1:0] rem_ff, rem_in;
   logic [ShW-1:0]     dsh_ff, dsh_in;
   logic [RatioW-1:0]  quot_ff, quot_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               ge;

   always_comb begin
      ge      = ({{(ShW-DivNumW){1'b0}}, rem_ff} >= dsh_ff);
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.num;
         dsh_in  = ShW'(req.den) << (req.nbits - DivCntW'(1));
         quot_in = '0;
         cnt_in  = req.nbits;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) rem_in = rem_ff - DivNumW'(dsh_ff);
         quot_in = {quot_ff[RatioW-2:0], ge};
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff - DivCntW'(1);
         if (cnt_ff == DivCntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
endmodule

[rtl/core/ddhd_back.sv]
// Back end: per-symbol baseline update, ratio and hysteresis decision.
// Depends on ddhd_pkg, ddhd_ram and the shared divider (through ports).
module ddhd_back (
   input  logic                         clock,
   input  logic                         reset,
   input  ddhd_pkg::cfg_type            cfg,
   input  logic                         q_valid,
   input  ddhd_pkg::quote_type          q_head,
   output logic                         q_pop,
   output ddhd_pkg::div_req_type        div_req,
   input  ddhd_pkg::div_rsp_type        div_rsp,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic                         rsp_action,
   output logic [ddhd_pkg::SymW-1:0]    rsp_symbol,
   output logic [ddhd_pkg::RatioW-1:0]  rsp_ratio
);
   import ddhd_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_READ   = 4'd1;
   localparam logic [3:0] S_CHECK  = 4'd2;
   localparam logic [3:0] S_ADIV   = 4'd3;
   localparam logic [3:0] S_MUL    = 4'd4;
   localparam logic [3:0] S_UPD    = 4'd5;
   localparam logic [3:0] S_RATIO  = 4'd6;
   localparam logic [3:0] S_RDIV   = 4'd7;
   localparam logic [3:0] S_DECIDE = 4'd8;
   localparam logic [3:0] S_CLEAR  = 4'd9;

   logic [3:0]         state_ff, state_in;
   logic [SymW-1:0]    sym_ff, sym_in;
   logic [SymIdxW-1:0] idx_ff, idx_in;
   logic [SymIdxW-1:0] clr_ff, clr_in;
   logic [TsW-1:0]     ts_ff, ts_in;
   logic [SumW-1:0]    vol_ff, vol_in;
   row_type            row_ff, row_in;
   logic [BaseW-1:0]   bv_ff, bv_in;
   logic [AlphaW-1:0]  alpha_ff, alpha_in;
   logic [BaseW:0]     hi_ff, hi_in;
   logic [AlphaW-1:0]  lo_ff, lo_in;
   logic               up_ff, up_in;
   logic [RatioW-1:0]  ratio_ff, ratio_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_action_ff, rsp_action_in;
   logic [SymW-1:0]    rsp_symbol_ff, rsp_symbol_in;
   logic [RatioW-1:0]  rsp_ratio_ff, rsp_ratio_in;

   logic               rd_en;
   row_type            rd_row;
   logic [RowW-1:0]    rd_bits;
   logic               wr_en;
   logic [SymIdxW-1:0] wr_addr;
   row_type            wr_row;
   logic [TsW-1:0]     dt;
   logic [BaseW-1:0]   vv, diff;
   logic [BaseW:0]     step;
   logic [DivNumW-1:0] alpha_num;
   logic               warm, cool_block, fired, do_enter, do_exit;
   logic               in_range;

   assign rd_row = row_type'(rd_bits);

   ddhd_ram #(.WIDTH(RowW), .DEPTH(SymbolCount)) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (RowW'(wr_row)),
      .rd_en   (rd_en),
      .rd_addr (SymIdxW'(q_head.sym)),
      .rd_data (rd_bits)
   );

   always_comb begin
      state_in      = state_ff;
      sym_in        = sym_ff;
      idx_in        = idx_ff;
      clr_in        = clr_ff;
      ts_in         = ts_ff;
      vol_in        = vol_ff;
      row_in        = row_ff;
      bv_in         = bv_ff;
      alpha_in      = alpha_ff;
      hi_in         = hi_ff;
      lo_in         = lo_ff;
      up_in         = up_ff;
      ratio_in      = ratio_ff;
      rsp_action_in = rsp_action_ff;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_ratio_in  = rsp_ratio_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      q_pop         = 1'b0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_row        = '{base: bv_ff, first: row_ff.first, prev: ts_ff, enter: row_ff.enter,
                        valid: row_ff.valid, fired: row_ff.fired, seen: row_ff.seen};
      div_req       = '0;

      in_range   = (32'(q_head.sym) < 32'(SymbolCount));
      dt         = ts_ff - row_ff.prev;
      alpha_num  = DivNumW'(dt[35:0]) * DivNumW'(2 * AlphaEntries)
                 + DivNumW'({cfg.window_us, 3'b000});
      vv         = {vol_ff, 16'h0000};
      diff       = up_ff ? '0 : '0;
      step       = hi_ff + (BaseW+1)'(lo_ff);
      fired      = row_ff.fired;
      warm       = (ts_ff >= row_ff.first)
                && ((ts_ff - row_ff.first) >= TsW'(cfg.warmup_us));
      cool_block = row_ff.seen && ((ts_ff < row_ff.enter)
                || ((ts_ff - row_ff.enter) < TsW'(cfg.holdoff_us)));
      do_enter   = !fired && warm && (ratio_ff < cfg.enter_ratio) && !cool_block;
      do_exit    = fired && (ratio_ff > cfg.exit_ratio);

      unique case (state_ff)
         S_CLEAR: begin
            // one table row per cycle after reset
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_row  = '0;
            clr_in  = clr_ff + SymIdxW'(1);
            if (clr_ff == SymIdxW'(SymbolCount - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               sym_in = q_head.sym;
               idx_in = SymIdxW'(q_head.sym);
               ts_in  = q_head.ts;
               vol_in = q_head.vol;
               if (in_range) begin
                  rd_en    = 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            row_in   = rd_row;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            bv_in = row_ff.base;
            if (!row_ff.valid) begin
               // first quote of this symbol: baseline only
               wr_en     = 1'b1;
               wr_row    = '{base: vv, first: ts_ff, prev: ts_ff, enter: row_ff.enter,
                             valid: 1'b1, fired: row_ff.fired, seen: row_ff.seen};
               state_in  = S_IDLE;
            end else if ((ts_ff > row_ff.prev) && (cfg.window_us != 32'd0) && !fired) begin
               if (dt >= TsW'({cfg.window_us, 3'b000})) begin
                  alpha_in = AlphaOne;
                  state_in = S_MUL;
               end else begin
                  div_req.start = 1'b1;
                  div_req.num   = alpha_num;
                  div_req.den   = DivDenW'({cfg.window_us, 4'b0000});
                  div_req.nbits = DivCntW'(AlphaIdxW + 1);
                  state_in      = S_ADIV;
               end
            end else begin
               state_in = S_RATIO;
            end
         end
         S_ADIV: begin
            if (div_rsp.done) begin
               alpha_in = (32'(div_rsp.quot) >= 32'(AlphaEntries)) ? AlphaOne
                        : AlphaRom[div_rsp.quot[AlphaIdxW-1:0]];
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            up_in    = (vv >= bv_ff);
            diff     = (vv >= bv_ff) ? (vv - bv_ff) : (bv_ff - vv);
            hi_in    = (BaseW+1)'(diff[BaseW-1:16]) * (BaseW+1)'(alpha_ff);
            lo_in    = AlphaW'((33'(diff[15:0]) * 33'(alpha_ff)) >> 16);
            state_in = S_UPD;
         end
         S_UPD: begin
            bv_in    = up_ff ? (bv_ff + step[BaseW-1:0]) : (bv_ff - step[BaseW-1:0]);
            state_in = S_RATIO;
         end
         S_RATIO: begin
            if (bv_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_IDLE;
            end else if (BaseW'({vol_ff, 8'h00}) >= bv_ff) begin
               ratio_in = RatioMax;
               state_in = S_DECIDE;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = {vol_ff, 32'h0};
               div_req.den   = bv_ff;
               div_req.nbits = DivCntW'(RatioW);
               state_in      = S_RDIV;
            end
         end
         S_RDIV: begin
            if (div_rsp.done) begin
               ratio_in = div_rsp.quot;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // hold while a finished result still waits downstream and this quote has one too
            if (!((do_enter || do_exit) && rsp_valid_ff && !rsp_tready)) begin
               wr_en     = 1'b1;
               wr_row    = '{base: bv_ff, first: row_ff.first, prev: ts_ff,
                             enter: do_enter ? ts_ff : row_ff.enter,
                             valid: row_ff.valid,
                             fired: do_enter || (row_ff.fired && !do_exit),
                             seen: row_ff.seen || do_enter};
               if (do_enter || do_exit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_action_in = do_enter ? ActEnter : ActExit;
                  rsp_symbol_in = sym_ff;
                  rsp_ratio_in  = ratio_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_action = rsp_action_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_ratio  = rsp_ratio_ff;

   always_ff @(posedge clock) begin
      sym_ff        <= sym_in;
      idx_ff        <= idx_in;
      ts_ff         <= ts_in;
      vol_ff        <= vol_in;
      row_ff        <= row_in;
      bv_ff         <= bv_in;
      alpha_ff      <= alpha_in;
      hi_ff         <= hi_in;
      lo_ff         <= lo_in;
      up_ff         <= up_in;
      ratio_ff      <= ratio_in;
      rsp_action_ff <= rsp_action_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_ratio_ff  <= rsp_ratio_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
      end
   end
endmodule

[rtl/core/depth_drop_hysteresis_detector.sv]
// Channel    Dir  Contents
// req_*      in   book level: tdata {volume, timestamp, symbol}, tuser side, tlast end of quote
// rsp_*      out  signal: tdata {ratio, symbol}, tuser action (0 enter, 1 exit)
// csr_*      in   register writes, index per register list, no read-back
//
// Levels are taken one per cycle while the queue is not full; a quote waits in a two-entry
// queue for the back end. Back end per quote: a first quote only stores its baseline; otherwise
// the shared divider may be used for the alpha index and for the ratio.
// req_tready drops only while the queue is full; a pending result waits in an output register
// and, when the next quote has a result too, holds the back end in its decision step until taken.
// Reset (synchronous, active high) starts a pass that clears all 256 rows of the per-symbol table.
// Depends on ddhd_pkg, ddhd_front, ddhd_fifo, ddhd_div, ddhd_back, ddhd_ram and the defines.
`include "depth_drop_hysteresis_detector_defines.svh"

module depth_drop_hysteresis_detector (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ddhd_pkg::ReqDatW-1:0]   req_tdata,  // symbol[7:0], timestamp[70:8], volume[102:71]
   input  logic                           req_tuser,  // level side
   input  logic                           req_tlast,  // last level of quote
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ddhd_pkg::RspDatW-1:0]   rsp_tdata,  // symbol[7:0], ratio[31:8]
   output logic                           rsp_tuser,  // action
   input  logic                           csr_we,
   input  logic [ddhd_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [ddhd_pkg::CsrDatW-1:0]   csr_wdata
);
   import ddhd_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        fifo_push, fifo_pop, fifo_full, fifo_ne;
   quote_type   push_quote, head_quote;
   div_req_type div_req;
   div_rsp_type div_rsp;
   logic [SymW-1:0]   rsp_symbol;
   logic [RatioW-1:0] rsp_ratio;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CsrSideSelect: cfg_in.side_select = csr_wdata[0];
            CsrWindow:     cfg_in.window_us   = csr_wdata;
            CsrWarmup:     cfg_in.warmup_us   = csr_wdata;
            CsrEnterRatio: cfg_in.enter_ratio = csr_wdata[RatioW-1:0];
            CsrExitRatio:  cfg_in.exit_ratio  = csr_wdata[RatioW-1:0];
            CsrCooldown:   cfg_in.holdoff_us  = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{side_select: 1'b0, window_us: 32'd1000000, warmup_us: 32'd0,
                     enter_ratio: 24'd32768, exit_ratio: 24'd52429, holdoff_us: 32'd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ddhd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .side_select (cfg_ff.side_select),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .sym         (req_tdata[7:0]),
      .ts          (req_tdata[70:8]),
      .side        (req_tuser),
      .vol         (req_tdata[102:71]),
      .last        (req_tlast),
      .q_full      (fifo_full),
      .q_push      (fifo_push),
      .q_data      (push_quote)
   );

   ddhd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (push_quote),
      .pop       (fifo_pop),
      .full      (fifo_full),
      .not_empty (fifo_ne),
      .head      (head_quote)
   );

   ddhd_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   ddhd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (fifo_ne),
      .q_head     (head_quote),
      .q_pop      (fifo_pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_action (rsp_tuser),
      .rsp_symbol (rsp_symbol),
      .rsp_ratio  (rsp_ratio)
   );

   assign rsp_tdata = {rsp_ratio, rsp_symbol};

   `DDHD_ASSERT_NOW(a_queue_no_overflow, fifo_push, !fifo_full, "quote queue overflow")
   `DDHD_ASSERT_NOW(a_enter_below, rsp_tvalid && (rsp_tuser == ActEnter), rsp_ratio < cfg_ff.enter_ratio, "enter ratio not below threshold")
   `DDHD_ASSERT_NOW(a_exit_above, rsp_tvalid && (rsp_tuser == ActExit), rsp_ratio > cfg_ff.exit_ratio, "exit ratio not above threshold")

endmodule

[test/ddhd_checker.sv]
// Scoreboard for the depth drop hysteresis detector: follows the register writes,
// predicts each signal from the accepted book levels and compares the rsp transactions.
// Depends on ddhd_pkg.
module ddhd_checker
   import ddhd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [ReqDatW-1:0] req_tdata,
   input  logic               req_tuser,
   input  logic               req_tlast,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [RspDatW-1:0] rsp_tdata,
   input  logic               rsp_tuser,
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [CsrDatW-1:0] csr_wdata,
   output int                 failures,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic              action;
      logic [SymW-1:0]   sym;
      logic [RatioW-1:0] ratio;
   } signal_type;

   signal_type expected_signals[$];

   logic [63:0] alpha_tab [AlphaEntries];

   // register copies
   logic              c_side;
   logic [31:0]       c_window, c_warm, c_cool;
   logic [RatioW-1:0] c_enter, c_exit;

   // quote accumulator and per-symbol state
   logic [SumW:0]    depth_sum;
   logic             have_base [SymbolCount];
   logic [BaseW-1:0] base_q    [SymbolCount];
   logic [TsW-1:0]   t_first   [SymbolCount];
   logic [TsW-1:0]   t_prev    [SymbolCount];
   logic             fired     [SymbolCount];
   logic             entered   [SymbolCount];
   logic [TsW-1:0]   t_enter   [SymbolCount];

   initial begin
      logic [63:0] step_h, term, decay, pw;
      step_h = (64'd1 << 35) / AlphaEntries;
      term   = 64'd1 << 32;
      decay  = 64'd1 << 32;
      pw     = 64'd1 << 32;
      for (int n = 1; n <= 24; n++) begin
         term = ((term * step_h) >> 32) / n;
         decay = (n % 2) ? decay - term : decay + term;
      end
      for (int i = 0; i < AlphaEntries; i++) begin
         alpha_tab[i] = ((64'd1 << 32) - pw + 64'd32768) >> 16;
         pw = (pw * decay + 64'h80000000) >> 32;
      end
   end

   function automatic logic [63:0] alpha_of(logic [63:0] dt);
      logic [63:0] w, idx;
      w = c_window;
      if (dt >= 8 * w) return 64'(AlphaOne);
      idx = (dt * 2 * AlphaEntries + 8 * w) / (16 * w);
      if (idx >= AlphaEntries) return 64'(AlphaOne);
      return alpha_tab[idx];
   endfunction

   function automatic logic [63:0] weighted(logic [63:0] d, logic [63:0] a);
      return (d >> 16) * a + (((d & 64'hFFFF) * a) >> 16);
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      failures++;
   endtask

   task automatic predict_level(logic [SymW-1:0] sym, logic [TsW-1:0] ts, logic side,
                                logic [VolW-1:0] vol, logic last);
      logic [63:0] qv, bv, vv, a, ratio;
      logic [79:0] num;
      logic        warm;
      signal_type  s;
      if (side == c_side) begin
         depth_sum = depth_sum + vol;
         if (depth_sum > SumMax) depth_sum = SumMax;
      end
      if (!last) return;
      qv = depth_sum;
      depth_sum = '0;
      if (!have_base[sym]) begin
         have_base[sym] = 1'b1;
         base_q[sym]    = BaseW'(qv << 16);
         t_first[sym]   = ts;
         t_prev[sym]    = ts;
         return;
      end
      if (ts > t_prev[sym] && c_window != 0 && !fired[sym]) begin
         a  = alpha_of(64'(ts - t_prev[sym]));
         bv = base_q[sym];
         vv = qv << 16;
         if (vv >= bv) bv = bv + weighted(vv - bv, a);
         else bv = bv - weighted(bv - vv, a);
         base_q[sym] = BaseW'(bv);
      end
      t_prev[sym] = ts;
      bv = base_q[sym];
      if (bv == 0) return;
      if ((qv << 8) >= bv) ratio = 64'(RatioMax);
      else begin
         num   = 80'(qv) << 32;
         ratio = 64'(num / 80'(bv)) & 64'hFFFFFF;
      end
      warm = ts >= t_first[sym] && 64'(ts - t_first[sym]) >= 64'(c_warm);
      if (!fired[sym]) begin
         if (!warm || ratio >= 64'(c_enter)) return;
         if (entered[sym] && (ts < t_enter[sym] ||
             64'(ts - t_enter[sym]) < 64'(c_cool))) return;
         fired[sym]   = 1'b1;
         entered[sym] = 1'b1;
         t_enter[sym] = ts;
         s.action = ActEnter;
      end else begin
         if (ratio <= 64'(c_exit)) return;
         fired[sym] = 1'b0;
         s.action = ActExit;
      end
      s.sym   = sym;
      s.ratio = RatioW'(ratio);
      expected_signals.push_back(s);
   endtask

   always @(posedge clock) begin
      signal_type s;
      if (reset) begin
         c_side    <= 1'b0;
         c_window  <= 32'd1000000;
         c_warm    <= '0;
         c_enter   <= 24'd32768;
         c_exit    <= 24'd52429;
         c_cool    <= '0;
         depth_sum = '0;
         for (int i = 0; i < SymbolCount; i++) begin
            have_base[i] = 1'b0;
            fired[i]     = 1'b0;
            entered[i]   = 1'b0;
         end
         expected_signals.delete();
         failures = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CsrSideSelect: c_side   <= csr_wdata[0];
               CsrWindow:     c_window <= csr_wdata;
               CsrWarmup:     c_warm   <= csr_wdata;
               CsrEnterRatio: c_enter  <= csr_wdata[RatioW-1:0];
               CsrExitRatio:  c_exit   <= csr_wdata[RatioW-1:0];
               CsrCooldown:   c_cool   <= csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_level(req_tdata[7:0], req_tdata[70:8], req_tuser, req_tdata[102:71],
                          req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_signals.size() == 0)
               report_mismatch($sformatf("unexpected signal sym %0d action %0d",
                                         rsp_tdata[7:0], rsp_tuser));
            else begin
               s = expected_signals.pop_front();
               if (rsp_tuser !== s.action)
                  report_mismatch($sformatf("action got %0d exp %0d", rsp_tuser, s.action));
               if (rsp_tdata[7:0] !== s.sym)
                  report_mismatch($sformatf("symbol got %0d exp %0d", rsp_tdata[7:0], s.sym));
               if (rsp_tdata[31:8] !== s.ratio)
                  report_mismatch($sformatf("ratio got %h exp %h", rsp_tdata[31:8], s.ratio));
            end
         end
      end
      pending = expected_signals.size();
   end

endmodule

[test/tb_depth_drop_hysteresis_detector.sv]
// Stimulus and verdict for the depth drop hysteresis detector: directed quotes, then
// random quote streams over several register settings and idle patterns.
// Depends on ddhd_pkg, the detector RTL and ddhd_checker.
module tb_depth_drop_hysteresis_detector;
   import ddhd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [ReqDatW-1:0] req_tdata = '0;
   logic               req_tuser = 1'b0;
   logic               req_tlast = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RspDatW-1:0] rsp_tdata;
   logic               rsp_tuser;
   logic               csr_we = 1'b0;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [CsrDatW-1:0] csr_wdata = '0;
   logic               hold_go = 1'b0;
   int                 failures, pending;

   int          idle_pct = 0, stall_pct = 0, hold_left = 0, level_count = 0;
   logic        cfg_side = 1'b0;
   logic [31:0] cfg_window = 32'd1000000;
   logic [TsW-1:0] t_next [SymbolCount];
   int unsigned    depth_scale [SymbolCount];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   depth_drop_hysteresis_detector uut (.*);

   ddhd_checker scoreboard (.*);

   // receiver: random stalls plus a counted long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
      end else begin
         if (hold_go) hold_left = 600;
         else if (hold_left > 0) hold_left--;
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      #3ms;
      $display("tb_depth_drop_hysteresis_detector: FAIL");
      $finish;
   end

   task automatic send_level(logic [SymW-1:0] sym, logic [TsW-1:0] ts, logic side,
                             logic [VolW-1:0] vol, logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, vol, ts, sym};
      req_tuser  <= side;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      level_count++;
   endtask

   // quote of one level per side, the ask level closes it
   task automatic two_sided(logic [SymW-1:0] sym, logic [TsW-1:0] ts,
                            logic [VolW-1:0] bid, logic [VolW-1:0] ask);
      send_level(sym, ts, 1'b0, bid, 1'b0);
      send_level(sym, ts, 1'b1, ask, 1'b1);
   endtask

   // the back end may still hold up to three quotes that give no result
   task automatic drain();
      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_regs(logic side, logic [31:0] win, logic [31:0] warm,
                           logic [23:0] enter_r, logic [23:0] exit_r, logic [31:0] cool);
      logic [CsrDatW-1:0] vals [6];
      vals = '{32'(side), win, warm, 32'(enter_r), 32'(exit_r), cool};
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CsrIdxW'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we   <= 1'b0;
      cfg_side   = side;
      cfg_window = win;
   endtask

   task automatic random_quote();
      logic [SymW-1:0] sym;
      logic [63:0]     dt;
      int unsigned     w, levels, target, pick;
      logic            noise;
      sym = ($urandom_range(99) < 85) ? SymW'($urandom_range(7)) : SymW'($urandom);
      w = (cfg_window == 0 || cfg_window > 32'd1000000) ? 32'd5000 : cfg_window;
      pick = $urandom_range(99);
      if (pick < 8) dt = '0;
      else if (pick < 45) dt = 64'($urandom_range(1, w));
      else if (pick < 90) dt = 64'(w) + 64'($urandom_range(3 * w));
      else dt = 64'($urandom_range(10 * w));
      if ($urandom_range(99) < 5) t_next[sym] = t_next[sym] - TsW'($urandom_range(2 * w));
      else t_next[sym] = t_next[sym] + TsW'(dt);
      // occasional depth collapse or recovery per symbol
      pick = $urandom_range(99);
      if (pick < 15) depth_scale[sym] = $urandom_range(50, 400);
      else if (pick < 35) depth_scale[sym] = $urandom_range(2000, 100000);
      noise  = $urandom_range(99) < 5;
      levels = $urandom_range(1, 5);
      for (int i = 0; i < levels; i++) begin
         target = noise ? $urandom : $urandom_range(depth_scale[sym]);
         send_level(sym, t_next[sym], ($urandom_range(99) < 70) ? cfg_side : !cfg_side,
                    VolW'(target), i == levels - 1);
      end
   endtask

   initial begin
      logic [TsW-1:0] top_ts;
      for (int s = 0; s < SymbolCount; s++) begin
         t_next[s] = (s % 4 == 0) ? TsW'(63'h7FFF_FF00_0000_0000 + $urandom) : TsW'($urandom);
         depth_scale[s] = $urandom_range(2000, 100000);
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: baseline, drop to enter, recovery to exit
      two_sided(8'd0, 63'd1000, 32'd1000, 32'd5);
      two_sided(8'd0, 63'd2000, 32'd100, 32'd5);
      two_sided(8'd0, 63'd2000, 32'd90, 32'd5);
      two_sided(8'd0, 63'd3000, 32'd2000, 32'd5);
      // zero baseline never signals
      two_sided(8'd1, 63'd0, 32'd0, 32'hFFFFFFFF);
      two_sided(8'd1, 63'd10, 32'd0, 32'd7);
      // top of the timestamp range, time going backwards after the first quote
      top_ts = 63'h7FFF_FFFF_FFFF_FFFF;
      two_sided(8'd255, top_ts - 63'd100, 32'hFFFFFFFF, 32'd0);
      two_sided(8'd255, top_ts - 63'd200, 32'd1, 32'd0);
      two_sided(8'd255, top_ts, 32'd1, 32'd0);
      // volume sum saturates at the 40-bit ceiling
      for (int i = 0; i < 300; i++)
         send_level(8'd2, 63'd5, 1'b0, 32'hFFFFFFFF, i == 299);
      two_sided(8'd2, 63'd6, 32'hFFFFFFFF, 32'd0);
      drain();

      for (int phase = 0; level_count < 1800; phase++) begin
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 77; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 77; end
            default: begin idle_pct = 12; stall_pct = 12; end
         endcase
         case (phase)
            0: set_regs(1'b1, 32'd0, 32'd0, 24'hFFFFFF, 24'hFFFFFF, 32'd0);
            1: set_regs(1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'd0, 24'd0, 32'hFFFFFFFF);
            2: set_regs(1'b1, 32'd1, 32'd0, 24'd40000, 24'd0, 32'd0);
            default:
               set_regs(1'($urandom_range(1)), $urandom_range(500, 60000),
                        $urandom_range(20000), 24'($urandom_range(16000, 45000)),
                        24'($urandom_range(45000, 90000)), $urandom_range(30000));
         endcase
         if (phase == 4) begin
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
         end
         for (int q = 0; q < 70; q++) random_quote();
         drain();
      end

      if (failures == 0 && pending == 0) begin
         $display("tb_depth_drop_hysteresis_detector: PASS");
      end else begin
         $display("tb_depth_drop_hysteresis_detector: FAIL");
      end
      $finish;
   end

endmodule

[depth_drop_hysteresis_detector.f]
+incdir+rtl/core
rtl/core/ddhd_pkg.sv
rtl/core/ddhd_ram.sv
rtl/core/ddhd_front.sv
rtl/core/ddhd_fifo.sv
rtl/core/ddhd_div.sv
rtl/core/ddhd_back.sv
rtl/core/depth_drop_hysteresis_detector.sv
test/ddhd_checker.sv
test/tb_depth_drop_hysteresis_detector.sv
